[hw/rtl/sorb_pkg.sv]
// Package for the sawtooth overwrite ring buffer: widths, depth, command
// types and status struct shared by the front, the back and the top level.
// No dependencies.
`timescale 1ns / 1ps

package sorb_pkg;

  // Ring geometry
  localparam int DEPTH = 32;
  localparam int PTR_W = $clog2(DEPTH);

  // Field widths
  localparam int SAW_W = 7;
  localparam int CNT_W = 8;
  localparam int CMP_W = (CNT_W > PTR_W) ? CNT_W : PTR_W;

  // Reset value of the saw_max register
  localparam logic [SAW_W-1:0] SAW_MAX_RST = SAW_W'(100);

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_IDX_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CNT_W-1:0]   count;
  } cmd_t;

  typedef struct packed {
    logic               busy;
    logic [PTR_W-1:0]   fill;
  } bk_status_t;

endpackage

[hw/rtl/sorb_if.sv]
// Valid/ready channel interfaces for the input and result transactions.
// Depends on sorb_pkg.
`timescale 1ns / 1ps

interface sorb_in_if
  import sorb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [CNT_W-1:0]   read_count;

  modport source (output valid, output action, output read_count, input ready);
  modport sink   (input valid, input action, input read_count, output ready);
endinterface

interface sorb_out_if
  import sorb_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [SAW_W-1:0]   data;
  logic               last;
  logic               empty_res;

  modport source (output valid, output data, output last, output empty_res, input ready);
  modport sink   (input valid, input data, input last, input empty_res, output ready);
endinterface

[hw/rtl/sorb_front.sv]
// Front end: accepts input transactions, classifies them into commands and
// holds them in a short queue for the back end. Depends on sorb_pkg, sorb_if.
`timescale 1ns / 1ps

module sorb_front
  import sorb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  sorb_in_if.sink         in_ch,
  output logic            q_valid,
  output cmd_t            q_cmd,
  input  logic            q_pop
);

  cmd_t                 slots [Q_DEPTH];
  logic [Q_IDX_W-1:0]   wr_idx;
  logic [Q_IDX_W-1:0]   rd_idx;
  logic [Q_CNT_W-1:0]   cnt;
  logic                 push;
  logic                 pop;
  cmd_t                 cmd_in;

  // Classify the incoming transaction
  always_comb begin
    cmd_in.count = in_ch.read_count;
    if (in_ch.action == ACT_TICK) begin
      cmd_in.kind = CMD_TICK;
    end else if (in_ch.read_count == '0) begin
      cmd_in.kind = CMD_READ_NONE;
    end else begin
      cmd_in.kind = CMD_READ;
    end
  end

  assign in_ch.ready = (cnt != Q_CNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt != '0);
  assign pop         = q_pop && q_valid;
  assign q_cmd       = slots[rd_idx];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_idx] <= cmd_in;
    end
  end

  // Queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_idx <= (wr_idx == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= (rd_idx == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

[hw/rtl/sorb_back.sv]
// Back end: ring memory, pointers, sawtooth generator and the drain
// sequencer that drives the result channel. Depends on sorb_pkg, sorb_if.
`timescale 1ns / 1ps

module sorb_back
  import sorb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SAW_W-1:0]  cfg_wr_data,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  sorb_out_if.source        out_ch,
  output bk_status_t        status
);

  logic [SAW_W-1:0] ring_store [DEPTH];

  logic [PTR_W-1:0] rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] fill, fill_next;
  logic [PTR_W-1:0] remain, remain_next;
  logic [SAW_W-1:0] saw, saw_next;
  logic [SAW_W-1:0] saw_max;
  logic             busy, busy_next;
  logic             ov, ov_next;
  logic [SAW_W-1:0] data;
  logic             last;
  logic             empty_res;

  logic             slot_free;
  logic             tick_do;
  logic             issue;
  logic             issue_last;
  logic             issue_empty;
  logic [PTR_W-1:0] rd_inc;
  logic [PTR_W-1:0] wr_inc;
  logic [SAW_W-1:0] saw_inc;
  logic [CMP_W-1:0] want_w;
  logic [CMP_W-1:0] fill_w;
  logic [PTR_W-1:0] n_take;

  assign rd_inc  = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  assign wr_inc  = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign saw_inc = saw + 1'b1;

  // Entries a read takes: the smaller of the request and the fill
  assign want_w = CMP_W'(q_cmd.count);
  assign fill_w = CMP_W'(fill);
  assign n_take = (want_w < fill_w) ? PTR_W'(want_w) : fill;

  // Output register is free when empty or being taken this cycle
  assign slot_free = !ov || out_ch.ready;

  // Sequencer: next state and control
  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    remain_next = remain;
    saw_next    = saw;
    busy_next   = busy;
    ov_next     = (ov && out_ch.ready) ? 1'b0 : ov;
    q_pop       = 1'b0;
    tick_do     = 1'b0;
    issue       = 1'b0;
    issue_last  = 1'b0;
    issue_empty = 1'b0;

    if (busy) begin
      // drain the rest of a read, one entry per cycle while the output register is free
      if (slot_free) begin
        issue       = 1'b1;
        issue_last  = (remain == PTR_W'(1));
        rd_ptr_next = rd_inc;
        fill_next   = fill - 1'b1;
        remain_next = remain - 1'b1;
        busy_next   = (remain != PTR_W'(1));
      end
    end else if (q_valid) begin
      unique case (q_cmd.kind)
        CMD_TICK: begin
          q_pop       = 1'b1;
          tick_do     = 1'b1;
          wr_ptr_next = wr_inc;
          // ring full: drop the oldest entry
          if (rd_ptr == wr_inc) begin
            rd_ptr_next = rd_inc;
          end else begin
            fill_next = fill + 1'b1;
          end
          saw_next = (saw_inc > saw_max) ? '0 : saw_inc;
        end
        CMD_READ, CMD_READ_NONE: begin
          if (slot_free) begin
            q_pop = 1'b1;
            issue = 1'b1;
            if (n_take == '0) begin
              issue_empty = 1'b1;
              issue_last  = 1'b1;
            end else begin
              issue_last  = (n_take == PTR_W'(1));
              rd_ptr_next = rd_inc;
              fill_next   = fill - 1'b1;
              remain_next = n_take - 1'b1;
              busy_next   = (n_take != PTR_W'(1));
            end
          end
        end
      endcase
    end

    if (issue) begin
      ov_next = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr  <= '0;
      wr_ptr  <= '0;
      fill    <= '0;
      remain  <= '0;
      saw     <= '0;
      busy    <= 1'b0;
      ov      <= 1'b0;
      saw_max <= SAW_MAX_RST;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
      remain <= remain_next;
      saw    <= saw_next;
      busy   <= busy_next;
      ov     <= ov_next;
      if (cfg_wr_en) begin
        saw_max <= cfg_wr_data;
      end
    end
  end

  // Ring memory write port
  always_ff @(posedge clk) begin
    if (tick_do) begin
      ring_store[wr_ptr] <= saw;
    end
  end

  // Ring memory read port, registered straight into the result register
  always_ff @(posedge clk) begin
    if (issue) begin
      last      <= issue_last;
      empty_res <= issue_empty;
      if (issue_empty) begin
        data <= '0;
      end else begin
        data <= ring_store[rd_ptr];
      end
    end
  end

  assign out_ch.valid     = ov;
  assign out_ch.data      = data;
  assign out_ch.last      = last;
  assign out_ch.empty_res = empty_res;

  assign status.busy = busy;
  assign status.fill = fill;

endmodule

[hw/rtl/sawtooth_overwrite_ring_buffer.sv]
// Sawtooth ring buffer that overwrites its oldest entry: a tick stores one
// sample in the back end; a read of n entries (n the smaller of read_count
// and the fill, at most 31) yields n results at one per cycle while the
// receiver takes them, paced by the single read port of the ring memory, and
// an empty or zero-count read yields one result flagged empty_res. The first
// result of a command is registered and appears in the cycle after the back
// end takes the command; a two-entry command queue lets input transactions be
// taken while a read is draining. No clearing pass after reset. Depends on
// sorb_pkg, sorb_if, sorb_front, sorb_back.
`timescale 1ns / 1ps

module sawtooth_overwrite_ring_buffer
  import sorb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SAW_W-1:0]  cfg_wr_data,
  sorb_in_if.sink           in_ch,
  sorb_out_if.source        out_ch
);

  logic       q_valid;
  logic       q_pop;
  cmd_t       q_cmd;
  bk_status_t status;

  // Accept and classify
  sorb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // Execute against the ring
  sorb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_ch      (out_ch),
    .status      (status)
  );

  // An empty read result carries zero data and closes its read
  a_empty_res: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.empty_res) |-> (out_ch.data == '0 && out_ch.last))
    else $error("empty result with nonzero data or without last");

  // While a read drains, the result register stays loaded
  a_busy_valid: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> out_ch.valid)
    else $error("drain in progress without a pending result");

  // No command leaves the queue while a read is draining
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !q_pop)
    else $error("command taken during drain");

  // A tick always leaves at least one entry in the ring
  a_tick_fill: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.kind == CMD_TICK) |=> (status.fill != '0))
    else $error("ring empty after a tick");

endmodule

[tb/tb.sv]
// Self-checking testbench for the sawtooth overwrite ring buffer.
// Holds a sample scoreboard class and the drivers for both channels and the register.
// Depends on sorb_pkg, sorb_if and sawtooth_overwrite_ring_buffer.
`timescale 1ns / 1ps

// One drained sample as it should leave the block
typedef struct {
  logic [sorb_pkg::SAW_W-1:0] data;
  logic                       last;
  logic                       empty_res;
} drained_t;

// Mirrors the ring contents and queues the samples each read should return
class sample_scoreboard;
  logic [sorb_pkg::SAW_W-1:0] ring [sorb_pkg::DEPTH];
  int unsigned                rd_ptr;
  int unsigned                wr_ptr;
  int unsigned                fill;
  logic [sorb_pkg::SAW_W-1:0] saw;
  logic [sorb_pkg::SAW_W-1:0] saw_max;
  drained_t                   expected_q [$];
  int unsigned                errors;
  bit                         top_stored;

  function new();
    rd_ptr     = 0;
    wr_ptr     = 0;
    fill       = 0;
    saw        = '0;
    saw_max    = sorb_pkg::SAW_MAX_RST;
    errors     = 0;
    top_stored = 1'b0;
  endfunction

  // Update the ring on an accepted input transaction
  function void note_input(logic act, logic [sorb_pkg::CNT_W-1:0] cnt);
    int unsigned n;
    int unsigned i;
    drained_t    r;
    if (act == sorb_pkg::ACT_TICK) begin
      ring[wr_ptr] = saw;
      if (saw == '1) top_stored = 1'b1;
      wr_ptr = (wr_ptr + 1) % sorb_pkg::DEPTH;
      // full ring: oldest sample is overwritten
      if (wr_ptr == rd_ptr) rd_ptr = (rd_ptr + 1) % sorb_pkg::DEPTH;
      else fill++;
      saw = saw + 1'b1;
      if (saw > saw_max) saw = '0;
    end else begin
      n = (cnt < fill) ? cnt : fill;
      if (n == 0) begin
        // nothing to drain: one empty marker
        r.data      = '0;
        r.last      = 1'b1;
        r.empty_res = 1'b1;
        expected_q.push_back(r);
      end else begin
        for (i = 0; i < n; i++) begin
          r.data      = ring[(rd_ptr + i) % sorb_pkg::DEPTH];
          r.last      = (i + 1 == n);
          r.empty_res = 1'b0;
          expected_q.push_back(r);
        end
        fill   = fill - n;
        rd_ptr = (rd_ptr + n) % sorb_pkg::DEPTH;
      end
    end
  endfunction

  // Compare one accepted result against the oldest expectation
  function void check_result(logic [sorb_pkg::SAW_W-1:0] data, logic last,
                             logic empty_res);
    drained_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result: data=%0d last=%0b empty_res=%0b",
                       data, last, empty_res));
      return;
    end
    want = expected_q.pop_front();
    if (want.data !== data || want.last !== last || want.empty_res !== empty_res)
      report($sformatf({"mismatch: expected data=%0d last=%0b empty_res=%0b, ",
                        "got data=%0d last=%0b empty_res=%0b"},
                       want.data, want.last, want.empty_res,
                       data, last, empty_res));
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction
endclass

module tb;
  import sorb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int HOLD_CYCLES  = 400;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [SAW_W-1:0] cfg_wr_data;
  bit               rx_hold;
  int unsigned      tx_idle_pct;
  int unsigned      rx_stall_pct;
  int unsigned      cycles = 0;
  sample_scoreboard sb;

  sorb_in_if  in_ch ();
  sorb_out_if out_ch ();

  sawtooth_overwrite_ring_buffer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Result side: check accepted transactions, stall at random or on hold
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.data, out_ch.last, out_ch.empty_res);
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one input transaction, with random idle cycles ahead of it
  task automatic send_item(input logic act, input logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.read_count <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(act, cnt);
  endtask

  task automatic send_random(input int unsigned tick_pct);
    logic             act;
    logic [CNT_W-1:0] cnt;
    act = ($urandom_range(99) < tick_pct) ? ACT_TICK : ACT_READ;
    case ($urandom_range(9))
      0: cnt = '0;
      1: cnt = '1;
      2, 3: cnt = CNT_W'($urandom_range(1, 4));
      default: cnt = CNT_W'($urandom);
    endcase
    send_item(act, cnt);
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned tick_pct,
                            input bit until_top);
    int unsigned k;
    k = 0;
    while (k < n_items || (until_top && !sb.top_stored)) begin
      send_random(tick_pct);
      k++;
    end
  endtask

  // Drain the block, let queued ticks settle, then write saw_max
  task automatic set_saw_max(input logic [SAW_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    sb.saw_max = v;
  endtask

  // Receiver holds off for a fixed stretch of cycles
  task automatic hold_receiver(input int unsigned n);
    rx_hold <= 1'b1;
    repeat (n) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  initial begin
    sb = new();
    rst              <= 1'b1;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.action     <= ACT_TICK;
    in_ch.read_count <= '0;
    rx_hold          <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty reads, zero-count read, partial and full drains
    send_item(ACT_READ, '0);
    send_item(ACT_READ, '1);
    repeat (3) send_item(ACT_TICK, CNT_W'($urandom));
    send_item(ACT_READ, '0);
    send_item(ACT_READ, 8'd1);
    send_item(ACT_READ, '1);
    send_item(ACT_READ, 8'd1);
    // saw_max at zero: sawtooth stuck at zero after the pending value
    set_saw_max('0);
    repeat (3) send_item(ACT_TICK, CNT_W'($urandom));
    send_item(ACT_READ, '1);
    // saw_max raised to 5, then lowered below the running value to force a wrap
    set_saw_max(7'd5);
    repeat (4) send_item(ACT_TICK, CNT_W'($urandom));
    send_item(ACT_READ, 8'd2);
    set_saw_max(7'd2);
    repeat (2) send_item(ACT_TICK, CNT_W'($urandom));
    send_item(ACT_READ, '1);

    // Random, no idling, widest sawtooth until the top value is stored
    set_saw_max('1);
    run_random(10, 95, 1'b1);

    // Sender mostly idle
    tx_idle_pct  = 83;
    rx_stall_pct = 0;
    set_saw_max(SAW_W'($urandom_range(1, 126)));
    run_random(8, 60, 1'b0);

    // Receiver mostly stalling
    tx_idle_pct  = 0;
    rx_stall_pct = 83;
    set_saw_max(SAW_MAX_RST);
    run_random(8, 55, 1'b0);

    // Both sides idle a quarter of the time
    tx_idle_pct  = 25;
    rx_stall_pct = 25;
    set_saw_max(7'd31);
    run_random(8, 60, 1'b0);

    // Receiver held off while the sender keeps offering: fill up and stall input
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_saw_max('1);
    fork
      hold_receiver(HOLD_CYCLES);
      begin
        repeat (8) send_item(ACT_TICK, CNT_W'($urandom));
        // second read waits behind the held result, the queue fills behind it
        repeat (2) send_item(ACT_READ, '1);
        repeat (4) send_item(ACT_TICK, CNT_W'($urandom));
        repeat (6) send_random(50);
      end
    join

    // Wrap up once every expected sample has come back
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
